// File: rtl/sha_pkg.sv
// Shared types and constants for the SHA-256 message hasher.
// Holds item structs, the controller state enum, core control struct and round tables.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

  typedef logic [31:0] word_t;

  // One input item: a message byte and its flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       message_end;
  } msg_item_t;

  // One result item: a digest word with its index
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Control from the sequencer to the round core
  typedef struct packed {
    logic load_w;
    logic load_v;
    logic round;
    logic fold;
  } core_ctl_t;

  localparam int BLK_WORDS = 16;
  localparam int HASH_WORDS = 8;
  localparam int ROUNDS = 64;

  // Sequencer last step indices
  localparam logic [6:0] LOAD_LAST  = 7'd16;
  localparam logic [6:0] VAR_LAST   = 7'd8;
  localparam logic [6:0] ROUND_LAST = 7'd63;
  localparam logic [6:0] FOLD_LAST  = 7'd8;

  // Block word positions used by padding, the pad byte, and last fill and digest word indices
  localparam logic [4:0] WI_LEN_HI  = 5'd14;
  localparam logic [4:0] WI_OVER    = 5'd16;
  localparam logic [3:0] ADDR_LEN_HI = 4'd14;
  localparam logic [3:0] ADDR_LEN_LO = 4'd15;
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam word_t INIT_H [HASH_WORDS] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

endpackage

// File: rtl/sha_wmem.sv
// Block word memory: sixteen 32-bit message words of the current block.
// One write port, one read port, registered read data. Uses sha_pkg.
`timescale 1ns / 1ps

module sha_wmem import sha_pkg::*; (
  input  logic       clk,
  input  logic       we,
  input  logic [3:0] waddr,
  input  word_t      wdata,
  input  logic [3:0] raddr,
  output word_t      rdata
);

  word_t mem [BLK_WORDS];

  // Write and read; read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sha_cmem.sv
// Chaining value memory: eight 32-bit hash words with per-entry valid bits.
// An entry not written since the last clear reads as the initial hash value. Uses sha_pkg.
`timescale 1ns / 1ps

module sha_cmem import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       we,
  input  logic [2:0] waddr,
  input  word_t      wdata,
  input  logic [2:0] raddr,
  output word_t      rdata
);

  word_t                  mem [HASH_WORDS];
  logic [HASH_WORDS-1:0]  valid;
  word_t                  rd_q;
  logic                   rd_valid;
  logic [2:0]             rd_addr;

  // Track written entries; clear drops them back to the initial value
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Store data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
    end
    rd_q    <= mem[raddr];
    rd_addr <= raddr;
  end

  assign rdata = rd_valid ? rd_q : INIT_H[rd_addr];

endmodule

// File: rtl/sha_core.sv
// Round core: working variables a..h, the 16-word message schedule window and
// one SHA-256 round per cycle. Uses sha_pkg.
`timescale 1ns / 1ps

module sha_core import sha_pkg::*; (
  input  logic       clk,
  input  core_ctl_t  ctl,
  input  logic [5:0] round_idx,
  input  word_t      wdata,
  input  word_t      cdata,
  output word_t      fold_sum
);

  word_t v [HASH_WORDS];
  word_t w [BLK_WORDS];
  word_t w_new;
  word_t t1;
  word_t t2;

  function automatic word_t bsig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Next schedule word and round temporaries
  always_comb begin
    w_new = w[0] + ssig0(w[1]) + w[9] + ssig1(w[14]);
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + ROUND_K[round_idx] + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Shift the schedule window: load from memory, or extend during rounds
  always_ff @(posedge clk) begin
    if (ctl.load_w || ctl.round) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        w[i] <= w[i + 1];
      end
      w[BLK_WORDS-1] <= ctl.load_w ? wdata : w_new;
    end
  end

  // Working variables: load chain, run rounds, shift out for the fold
  always_ff @(posedge clk) begin
    if (ctl.load_v || ctl.fold) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        v[i] <= v[i + 1];
      end
      if (ctl.load_v) begin
        v[HASH_WORDS-1] <= cdata;
      end
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign fold_sum = cdata + v[0];

endmodule

// File: rtl/sha256_message_hasher.sv
// SHA-256 over a byte stream. Bytes are packed into block words; a byte that
// fills a block starts a compression (load, 64 rounds, fold into the chaining memory)
// through the one round unit. An end item takes padding writes, one or two
// compressions, then reads out each digest word. Bytes are stalled while not idle.
// Reset is synchronous: control clears and the chaining memory reads as the initial value.
`timescale 1ns / 1ps

module sha256_message_hasher import sha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  msg_item_t    byte_item,
  output logic         digest_valid,
  input  logic         digest_stall,
  output digest_item_t digest_item
);

  state_t      state;
  state_t      state_next;
  state_t      ret;
  logic [6:0]  cnt;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [60:0] msg_bytes;
  logic [4:0]  wi;

  logic        in_take;
  logic        take_byte;
  logic        take_end;
  logic        out_take;
  logic        out_load;

  logic        bw_we;
  logic [3:0]  bw_addr;
  word_t       bw_data;
  word_t       bw_rdata;
  logic        cw_we;
  logic        cw_clear;
  word_t       cw_rdata;
  word_t       fold_sum;
  core_ctl_t   ctl;
  word_t       pad_word;

  assign in_take   = byte_valid && !byte_stall;
  assign take_byte = in_take && byte_item.has_byte;
  assign take_end  = in_take && byte_item.message_end;
  assign out_take  = digest_valid && !digest_stall;

  // Partial word with the 0x80 marker placed after the held bytes
  always_comb begin
    case (fill[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc[15:0], PAD_BYTE, 8'h0};
      2'd3:    pad_word = {acc[23:0], PAD_BYTE};
      default: pad_word = {PAD_BYTE, 24'h0};
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_byte && fill == FILL_LAST) begin
          state_next = ST_LOAD;
        end else if (take_end) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: state_next = ST_ZERO;
      ST_ZERO: begin
        if (wi == WI_LEN_HI) begin
          state_next = ST_LEN;
        end else if (wi == WI_OVER) begin
          state_next = ST_LOAD;
        end
      end
      ST_LEN: state_next = ST_LOAD;
      ST_LOAD: begin
        if (cnt == LOAD_LAST) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt == ROUND_LAST) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (cnt == FOLD_LAST) state_next = ret;
      end
      ST_EMIT_RD: begin
        if (!digest_valid || out_take) state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_next = (cnt[2:0] == WORD_LAST) ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory writes, core control, handshakes
  always_comb begin
    bw_we    = 1'b0;
    bw_addr  = fill[5:2];
    bw_data  = '0;
    cw_we    = 1'b0;
    cw_clear = 1'b0;
    ctl      = '0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take_byte && fill[1:0] == 2'd3) begin
          bw_we   = 1'b1;
          bw_data = {acc, byte_item.data_byte};
        end
      end
      ST_PAD: begin
        bw_we   = 1'b1;
        bw_data = pad_word;
      end
      ST_ZERO: begin
        if (wi == WI_LEN_HI) begin
          bw_we   = 1'b1;
          bw_addr = ADDR_LEN_HI;
          bw_data = msg_bytes[60:29];
        end else if (!wi[4]) begin
          bw_we   = 1'b1;
          bw_addr = wi[3:0];
        end
      end
      ST_LEN: begin
        bw_we   = 1'b1;
        bw_addr = ADDR_LEN_LO;
        bw_data = {msg_bytes[28:0], 3'b000};
      end
      ST_LOAD: begin
        ctl.load_w = (cnt != '0);
        ctl.load_v = (cnt != '0) && (cnt <= VAR_LAST);
      end
      ST_ROUND: ctl.round = 1'b1;
      ST_FOLD: begin
        ctl.fold = (cnt != '0);
        cw_we    = (cnt != '0);
      end
      ST_EMIT_LD: begin
        out_load = 1'b1;
        cw_clear = (cnt[2:0] == WORD_LAST);
      end
      default: ;
    endcase
  end

  assign byte_stall = (state != ST_IDLE);

  // State, step counter, padding word index and return point after compression
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ret   <= ST_IDLE;
      wi    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_LOAD, ST_ROUND, ST_FOLD: begin
          cnt <= (state_next != state) ? '0 : cnt + 7'd1;
        end
        ST_EMIT_LD: begin
          cnt <= (cnt[2:0] == WORD_LAST) ? '0 : cnt + 7'd1;
        end
        default: ;
      endcase
      if (state == ST_IDLE && state_next == ST_LOAD) begin
        ret <= take_end ? ST_PAD : ST_IDLE;
      end else if (state == ST_ZERO && state_next == ST_LOAD) begin
        ret <= ST_ZERO;
      end else if (state == ST_LEN) begin
        ret <= ST_EMIT_RD;
      end
      if (state == ST_PAD) begin
        wi <= {1'b0, fill[5:2]} + 5'd1;
      end else if (state == ST_ZERO) begin
        if (wi == WI_OVER) begin
          wi <= '0;
        end else if (wi != WI_LEN_HI) begin
          wi <= wi + 5'd1;
        end
      end
    end
  end

  // Byte packing and message length
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      msg_bytes <= '0;
    end else if (take_byte) begin
      fill      <= fill + 6'd1;
      msg_bytes <= msg_bytes + 61'd1;
    end else if (state == ST_EMIT_LD && cnt[2:0] == WORD_LAST) begin
      fill      <= '0;
      msg_bytes <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      acc <= {acc[15:0], byte_item.data_byte};
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (out_load) begin
      digest_valid <= 1'b1;
    end else if (out_take) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_item.digest_word <= cw_rdata;
      digest_item.word_index  <= cnt[2:0];
      digest_item.last_word   <= (cnt[2:0] == WORD_LAST);
    end
  end

  sha_wmem u_wmem (
    .clk   (clk),
    .we    (bw_we),
    .waddr (bw_addr),
    .wdata (bw_data),
    .raddr (cnt[3:0]),
    .rdata (bw_rdata)
  );

  sha_cmem u_cmem (
    .clk   (clk),
    .rst   (rst),
    .clear (cw_clear),
    .we    (cw_we),
    .waddr (cnt[2:0] - 3'd1),
    .wdata (fold_sum),
    .raddr (cnt[2:0]),
    .rdata (cw_rdata)
  );

  sha_core u_core (
    .clk       (clk),
    .ctl       (ctl),
    .round_idx (cnt[5:0]),
    .wdata     (bw_rdata),
    .cdata     (cw_rdata),
    .fold_sum  (fold_sum)
  );

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_LD |-> !digest_valid)
    else $error("digest load would overwrite a pending word");

  a_round_fold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && cnt == ROUND_LAST) |=> state == ST_FOLD && cnt == '0)
    else $error("rounds did not hand over to the fold");

  a_reinit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LD && cnt[2:0] == WORD_LAST)
      |=> state == ST_IDLE && fill == '0 && msg_bytes == '0)
    else $error("message state not reinitialized after digest");

  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ZERO |-> wi <= WI_OVER && wi != 5'd0 || ret == ST_ZERO)
    else $error("padding word index out of range");
`endif

endmodule
